/* rtl/rci_pkg.sv */
// ----------------------------------------------------------------------------
// rci_pkg
// Types, widths and helpers shared by the ray versus double cone blocks
// ----------------------------------------------------------------------------
package rci_pkg;

    localparam int FIELD_W    = 32;
    localparam int TAG_W      = 16;
    localparam int COEF_W     = 31;
    localparam int DISC_W     = 64;
    localparam int ROOT_W     = 32;
    localparam int NUM_BASE_W = 33;
    localparam int DEN_W      = 31;
    localparam int Q_W        = 32;
    localparam int DIV_LAT    = Q_W + 2;

    localparam logic signed [63:0] COEF_MAX64 = 64'sd1073741823;
    localparam logic signed [63:0] COEF_MIN64 = -64'sd1073741823;
    localparam logic signed [Q_W-1:0] T_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] T_MIN   = 32'sh8000_0000;

    typedef struct packed {
        logic signed [FIELD_W-1:0] origin_x;
        logic signed [FIELD_W-1:0] origin_y;
        logic signed [FIELD_W-1:0] origin_z;
        logic signed [FIELD_W-1:0] dir_x;
        logic signed [FIELD_W-1:0] dir_y;
        logic signed [FIELD_W-1:0] dir_z;
        logic [TAG_W-1:0]          object_tag;
    } rci_ray_t;

    typedef struct packed {
        logic [1:0]                hit_count;
        logic signed [FIELD_W-1:0] hit_t_first;
        logic signed [FIELD_W-1:0] hit_t_second;
        logic [TAG_W-1:0]          tag_out;
        logic                      degenerate;
    } rci_hit_t;

    typedef struct packed {
        logic signed [COEF_W-1:0]  a;
        logic signed [COEF_W-1:0]  b;
        logic signed [DISC_W-1:0]  disc;
        logic signed [FIELD_W-1:0] oy;
        logic signed [FIELD_W-1:0] dy;
        logic [TAG_W-1:0]          tag;
        logic                      degen;
    } rci_coef_t;

    function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [63:0] v);
        logic signed [COEF_W-1:0] r;
        if (v > COEF_MAX64)
        begin
            r = COEF_MAX64[COEF_W-1:0];
        end
        else if (v < COEF_MIN64)
        begin
            r = COEF_MIN64[COEF_W-1:0];
        end
        else
        begin
            r = v[COEF_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/rci_queue.sv */
// ----------------------------------------------------------------------------
// rci_queue
// Small first-in first-out queue of items held in registers
// ----------------------------------------------------------------------------
module rci_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  T     wr_data,
    output logic full,
    input  logic rd_en,
    output T     rd_data,
    output logic empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/rci_front.sv */
// ----------------------------------------------------------------------------
// rci_front
// Builds the quadratic coefficients and the discriminant of each ray
// ----------------------------------------------------------------------------
module rci_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  rci_pkg::rci_ray_t  ray,
    output logic               out_valid,
    output rci_pkg::rci_coef_t coef
);
    import rci_pkg::*;

    logic [3:0] v_reg;

    logic signed [63:0] dxx_reg, dyy_reg, dzz_reg;
    logic signed [63:0] oxd_reg, oyd_reg, ozd_reg;
    logic signed [63:0] oxx_reg, oyy_reg, ozz_reg;
    logic signed [FIELD_W-1:0] s1_oy_reg, s1_dy_reg;
    logic [TAG_W-1:0] s1_tag_reg;

    logic signed [63:0] sum_a, sum_b, sum_c;
    logic signed [COEF_W-1:0] s2_a_reg, s2_b_reg, s2_c_reg;
    logic signed [FIELD_W-1:0] s2_oy_reg, s2_dy_reg;
    logic [TAG_W-1:0] s2_tag_reg;

    logic signed [63:0] s3_bb_reg, s3_ac_reg;
    logic signed [COEF_W-1:0] s3_a_reg, s3_b_reg;
    logic signed [FIELD_W-1:0] s3_oy_reg, s3_dy_reg;
    logic [TAG_W-1:0] s3_tag_reg;

    rci_coef_t coef_reg;
    rci_coef_t coef_next;

    assign out_valid = v_reg[3];
    assign coef      = coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    // floor of each product by an arithmetic shift
    always_comb
    begin
        sum_a = (dxx_reg >>> FRAC_BITS) - (dyy_reg >>> FRAC_BITS) + (dzz_reg >>> FRAC_BITS);
        sum_b = ((oxd_reg >>> FRAC_BITS) - (oyd_reg >>> FRAC_BITS)
                + (ozd_reg >>> FRAC_BITS)) <<< 1;
        sum_c = (oxx_reg >>> FRAC_BITS) - (oyy_reg >>> FRAC_BITS) + (ozz_reg >>> FRAC_BITS);
    end

    always_comb
    begin
        coef_next.a     = s3_a_reg;
        coef_next.b     = s3_b_reg;
        coef_next.disc  = s3_bb_reg - (s3_ac_reg <<< 2);
        coef_next.oy    = s3_oy_reg;
        coef_next.dy    = s3_dy_reg;
        coef_next.tag   = s3_tag_reg;
        coef_next.degen = (s3_a_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxx_reg    <= ray.dir_x * ray.dir_x;
            dyy_reg    <= ray.dir_y * ray.dir_y;
            dzz_reg    <= ray.dir_z * ray.dir_z;
            oxd_reg    <= ray.origin_x * ray.dir_x;
            oyd_reg    <= ray.origin_y * ray.dir_y;
            ozd_reg    <= ray.origin_z * ray.dir_z;
            oxx_reg    <= ray.origin_x * ray.origin_x;
            oyy_reg    <= ray.origin_y * ray.origin_y;
            ozz_reg    <= ray.origin_z * ray.origin_z;
            s1_oy_reg  <= ray.origin_y;
            s1_dy_reg  <= ray.dir_y;
            s1_tag_reg <= ray.object_tag;

            s2_a_reg   <= sat_coef(sum_a);
            s2_b_reg   <= sat_coef(sum_b);
            s2_c_reg   <= sat_coef(sum_c);
            s2_oy_reg  <= s1_oy_reg;
            s2_dy_reg  <= s1_dy_reg;
            s2_tag_reg <= s1_tag_reg;

            s3_bb_reg  <= s2_b_reg * s2_b_reg;
            s3_ac_reg  <= s2_a_reg * s2_c_reg;
            s3_a_reg   <= s2_a_reg;
            s3_b_reg   <= s2_b_reg;
            s3_oy_reg  <= s2_oy_reg;
            s3_dy_reg  <= s2_dy_reg;
            s3_tag_reg <= s2_tag_reg;

            coef_reg   <= coef_next;
        end
    end

endmodule

/* rtl/rci_div.sv */
// ----------------------------------------------------------------------------
// rci_div
// Pipelined restoring divider, one quotient bit per stage, saturating result
// ----------------------------------------------------------------------------
module rci_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                          clk,
    input  logic                                          en,
    input  logic [rci_pkg::NUM_BASE_W+FRAC_BITS-1:0]      num,
    input  logic [rci_pkg::DEN_W-1:0]                     den,
    input  logic                                          neg,
    output logic signed [rci_pkg::Q_W-1:0]                quot
);
    import rci_pkg::*;

    localparam int NUM_W = NUM_BASE_W + FRAC_BITS;
    localparam logic [Q_W-1:0] HALF = 1 << (Q_W - 1);

    logic [NUM_W-1:0] rem_reg [Q_W+1];
    logic [DEN_W-1:0] den_reg [Q_W+1];
    logic             neg_reg [Q_W+1];
    logic             ovf_reg [Q_W+1];
    logic [Q_W-1:0]   q_reg   [Q_W+1];

    logic signed [Q_W-1:0] quot_reg;
    logic signed [Q_W-1:0] quot_next;

    assign quot = quot_reg;

    // quotient needs more than Q_W bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            neg_reg[0] <= neg;
            ovf_reg[0] <= (64'(num) >= (64'(den) << Q_W));
            q_reg[0]   <= '0;
        end
    end

    for (genvar j = 1; j <= Q_W; j++)
    begin : g_step
        logic [63:0] dsh;
        logic        ge;

        assign dsh = 64'(den_reg[j-1]) << (Q_W - j);
        assign ge  = (64'(rem_reg[j-1]) >= dsh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? rem_reg[j-1] - dsh[NUM_W-1:0] : rem_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
                q_reg[j]   <= {q_reg[j-1][Q_W-2:0], ge};
            end
        end
    end

    always_comb
    begin
        if (ovf_reg[Q_W])
        begin
            quot_next = neg_reg[Q_W] ? T_MIN : T_MAX;
        end
        else if (neg_reg[Q_W])
        begin
            quot_next = (q_reg[Q_W] > HALF) ? T_MIN : -$signed(q_reg[Q_W]);
        end
        else
        begin
            quot_next = q_reg[Q_W][Q_W-1] ? T_MAX : $signed(q_reg[Q_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= quot_next;
        end
    end

endmodule

/* rtl/rci_back.sv */
// ----------------------------------------------------------------------------
// rci_back
// Root of the discriminant, both roots, ordering and height test of each ray
// ----------------------------------------------------------------------------
module rci_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  rci_pkg::rci_coef_t coef,
    output logic               out_valid,
    output rci_pkg::rci_hit_t  hit
);
    import rci_pkg::*;

    localparam int SQ_N  = ROOT_W;
    localparam int REM_W = ROOT_W + 4;
    localparam int NUM_W = NUM_BASE_W + FRAC_BITS;
    localparam int LAT   = SQ_N + 1 + DIV_LAT + 3;
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    typedef struct packed {
        logic signed [FIELD_W-1:0] oy;
        logic signed [FIELD_W-1:0] dy;
        logic [TAG_W-1:0]          tag;
        logic                      degen;
        logic                      nohit;
    } side_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        side_t                    sd;
    } sq_side_t;

    logic [LAT-1:0] v_reg;

    logic [DISC_W-1:0] sq_rad_reg  [SQ_N];
    logic [REM_W-1:0]  sq_rem_reg  [SQ_N];
    logic [ROOT_W-1:0] sq_root_reg [SQ_N];
    sq_side_t          sq_side_reg [SQ_N];

    logic                    in_nohit;
    logic signed [33:0]      nb, n0, n1, sx;
    logic [32:0]             mag0, mag1;
    logic signed [COEF_W-1:0] a_abs;
    logic [NUM_W-1:0]        nm_num0_reg, nm_num1_reg;
    logic [DEN_W-1:0]        nm_den_reg;
    logic                    nm_neg0_reg, nm_neg1_reg;
    side_t                   nm_side_reg;

    side_t                   dv_side_reg [DIV_LAT];
    logic signed [Q_W-1:0]   q0, q1;

    logic signed [Q_W-1:0]   or_t0_reg, or_t1_reg;
    side_t                   or_side_reg;
    logic signed [63:0]      mu_p0_reg, mu_p1_reg;
    logic signed [Q_W-1:0]   mu_t0_reg, mu_t1_reg;
    side_t                   mu_side_reg;
    logic signed [63:0]      h0, h1;
    logic                    ht_k0_reg, ht_k1_reg;
    logic signed [Q_W-1:0]   ht_t0_reg, ht_t1_reg;
    side_t                   ht_side_reg;
    logic                    k0, k1;

    assign out_valid = v_reg[LAT-1];
    assign in_nohit  = coef.degen || coef.disc[DISC_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAT-2:0], in_valid};
        end
    end

    // integer square root, two radicand bits per stage
    for (genvar k = 0; k < SQ_N; k++)
    begin : g_sq
        logic [DISC_W-1:0] src_rad;
        logic [REM_W-1:0]  src_rem;
        logic [ROOT_W-1:0] src_root;
        sq_side_t          src_side;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign src_rad         = in_nohit ? '0 : coef.disc;
            assign src_rem         = '0;
            assign src_root        = '0;
            assign src_side.a      = coef.a;
            assign src_side.b      = coef.b;
            assign src_side.sd.oy  = coef.oy;
            assign src_side.sd.dy  = coef.dy;
            assign src_side.sd.tag = coef.tag;
            assign src_side.sd.degen = coef.degen;
            assign src_side.sd.nohit = in_nohit;
        end
        else
        begin : g_next
            assign src_rad  = sq_rad_reg[k-1];
            assign src_rem  = sq_rem_reg[k-1];
            assign src_root = sq_root_reg[k-1];
            assign src_side = sq_side_reg[k-1];
        end

        assign rem_sh = {src_rem[REM_W-3:0], src_rad[DISC_W-1:DISC_W-2]};
        assign trial  = REM_W'({src_root, 2'b01});
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rad_reg[k]  <= src_rad << 2;
                sq_rem_reg[k]  <= ge ? rem_sh - trial : rem_sh;
                sq_root_reg[k] <= {src_root[ROOT_W-2:0], ge};
                sq_side_reg[k] <= src_side;
            end
        end
    end

    // numerators -b -/+ s and their magnitudes
    always_comb
    begin
        nb    = -(34'(sq_side_reg[SQ_N-1].b));
        sx    = $signed({2'b00, sq_root_reg[SQ_N-1]});
        n0    = nb - sx;
        n1    = nb + sx;
        mag0  = n0[33] ? 33'(-n0) : n0[32:0];
        mag1  = n1[33] ? 33'(-n1) : n1[32:0];
        a_abs = sq_side_reg[SQ_N-1].a[COEF_W-1] ? -sq_side_reg[SQ_N-1].a
                                                : sq_side_reg[SQ_N-1].a;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_num0_reg <= {mag0, {FRAC_BITS{1'b0}}};
            nm_num1_reg <= {mag1, {FRAC_BITS{1'b0}}};
            nm_den_reg  <= {a_abs[COEF_W-2:0], 1'b0};
            nm_neg0_reg <= n0[33] ^ sq_side_reg[SQ_N-1].a[COEF_W-1];
            nm_neg1_reg <= n1[33] ^ sq_side_reg[SQ_N-1].a[COEF_W-1];
            nm_side_reg <= sq_side_reg[SQ_N-1].sd;
        end
    end

    rci_div #(.FRAC_BITS(FRAC_BITS)) u_div0 (
        .clk  (clk),
        .en   (en),
        .num  (nm_num0_reg),
        .den  (nm_den_reg),
        .neg  (nm_neg0_reg),
        .quot (q0)
    );

    rci_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
        .clk  (clk),
        .en   (en),
        .num  (nm_num1_reg),
        .den  (nm_den_reg),
        .neg  (nm_neg1_reg),
        .quot (q1)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_side_reg[0] <= nm_side_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                dv_side_reg[i] <= dv_side_reg[i-1];
            end
        end
    end

    always_comb
    begin
        h0 = 64'(mu_side_reg.oy) + (mu_p0_reg >>> FRAC_BITS);
        h1 = 64'(mu_side_reg.oy) + (mu_p1_reg >>> FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            or_t0_reg   <= (q0 > q1) ? q1 : q0;
            or_t1_reg   <= (q0 > q1) ? q0 : q1;
            or_side_reg <= dv_side_reg[DIV_LAT-1];

            mu_p0_reg   <= or_t0_reg * or_side_reg.dy;
            mu_p1_reg   <= or_t1_reg * or_side_reg.dy;
            mu_t0_reg   <= or_t0_reg;
            mu_t1_reg   <= or_t1_reg;
            mu_side_reg <= or_side_reg;

            ht_k0_reg   <= (h0 > -ONE) && (h0 < ONE);
            ht_k1_reg   <= (h1 > -ONE) && (h1 < ONE);
            ht_t0_reg   <= mu_t0_reg;
            ht_t1_reg   <= mu_t1_reg;
            ht_side_reg <= mu_side_reg;
        end
    end

    // pack kept roots, lower one first
    always_comb
    begin
        k0 = ht_k0_reg && !ht_side_reg.nohit;
        k1 = ht_k1_reg && !ht_side_reg.nohit;
        hit.hit_count    = 2'(k0) + 2'(k1);
        hit.hit_t_first  = k0 ? ht_t0_reg : (k1 ? ht_t1_reg : '0);
        hit.hit_t_second = (k0 && k1) ? ht_t1_reg : '0;
        hit.tag_out      = ht_side_reg.tag;
        hit.degenerate   = ht_side_reg.degen;
    end

endmodule

/* rtl/ray_cone_intersect.sv */
// ----------------------------------------------------------------------------
// ray_cone_intersect
// Ray against the truncated unit double cone, hit count and ordered hit t
// ----------------------------------------------------------------------------
// Takes one ray per clock while full is low and gives one result per ray, in
// arrival order. The solver holds the 32-stage square-root pipeline and the
// 34-stage divider pipeline. A 4-entry queue between the coefficient stage
// and the solver, and a 2-entry result queue, let either side stall on its own.
module ray_cone_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  rci_pkg::rci_ray_t ray,
    output logic              empty,
    input  logic              pop,
    output rci_pkg::rci_hit_t hit
);
    import rci_pkg::*;

    logic      front_en;
    logic      front_valid;
    rci_coef_t front_coef;
    logic      mid_full;
    logic      mid_empty;
    logic      mid_wr;
    logic      mid_rd;
    rci_coef_t mid_coef;
    logic      back_en;
    logic      back_valid;
    rci_hit_t  back_hit;
    logic      out_full;
    logic      out_wr;
    logic      out_rd;

    assign front_en = !(front_valid && mid_full);
    assign full     = !front_en;
    assign mid_wr   = front_valid && !mid_full;
    assign back_en  = !(back_valid && out_full);
    assign mid_rd   = back_en && !mid_empty;
    assign out_wr   = back_valid && !out_full;
    assign out_rd   = pop && !empty;

    rci_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (front_en),
        .in_valid  (push),
        .ray       (ray),
        .out_valid (front_valid),
        .coef      (front_coef)
    );

    rci_queue #(.T(rci_coef_t), .DEPTH(4)) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_wr),
        .wr_data (front_coef),
        .full    (mid_full),
        .rd_en   (mid_rd),
        .rd_data (mid_coef),
        .empty   (mid_empty)
    );

    rci_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (mid_rd),
        .coef      (mid_coef),
        .out_valid (back_valid),
        .hit       (back_hit)
    );

    rci_queue #(.T(rci_hit_t), .DEPTH(2)) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_wr),
        .wr_data (back_hit),
        .full    (out_full),
        .rd_en   (out_rd),
        .rd_data (hit),
        .empty   (empty)
    );

`ifndef SYNTHESIS
    a_degen_no_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && hit.degenerate) |-> (hit.hit_count == 2'd0))
        else $error("degenerate ray reported hits");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (hit.hit_count != 2'd3))
        else $error("hit count out of range");

    a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && hit.hit_count != 2'd2) |-> (hit.hit_t_second == '0))
        else $error("second t not cleared");

    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && hit.hit_count == 2'd2) |-> (hit.hit_t_first <= hit.hit_t_second))
        else $error("hits out of order");
`endif

endmodule
